/* hdl/segi_pkg.sv */
// ----------------------------------------------------------------------------
// segi_pkg: shared types and constants for the segment intersection pipeline
// Coordinate and fraction widths, derived datapath widths, outcome codes and
// the structs that travel between the front end, divider and output stage.
// ----------------------------------------------------------------------------
package segi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_W      = 24;

    // difference, product, numerator/denominator widths
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    // quotient bits: num*|delta|*2^F/den stays below 2^(COORD_BITS+FRAC_BITS)
    localparam int QW = COORD_BITS + FRAC_BITS;
    // numerator times delta magnitude
    localparam int MW = NW + COORD_BITS;
    // final point arithmetic width
    localparam int VW = COORD_BITS + FRAC_BITS + 2;
    localparam int EW = ((VW > OUT_W) ? VW : OUT_W) + 1;

    typedef enum logic [1:0] {
        OC_HIT  = 2'd0,
        OC_MISS = 2'd1,
        OC_PAR  = 2'd2
    } t_outcome;

    // data that rides along with an item through the divider
    typedef struct packed {
        t_outcome                      outcome;
        logic signed [COORD_BITS-1:0]  base_x;
        logic signed [COORD_BITS-1:0]  base_y;
        logic                          neg_x;
        logic                          neg_y;
        logic [NW-1:0]                 den;
    } t_side;

    // one divider lane: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QW-1:0] low;
    } t_lane;

endpackage

/* hdl/segi_front.sv */
// ----------------------------------------------------------------------------
// segi_front: cross products, range test and dividend setup
// Five register stages: differences, products, signed sums with sign
// normalization, range test, numerator-times-delta products.
// ----------------------------------------------------------------------------
module segi_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_x1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_y1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_x2,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_y2,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_x1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_y1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_x2,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_y2,
    output logic                                    o_valid,
    output segi_pkg::t_side                         o_side,
    output segi_pkg::t_lane                         o_lane_x,
    output segi_pkg::t_lane                         o_lane_y
);
    import segi_pkg::*;

    // stage 1: edge and offset vectors
    logic                         r1_vld;
    logic signed [DW-1:0]         r1_dx, r1_dy, r1_ex, r1_ey, r1_wx, r1_wy;
    logic signed [COORD_BITS-1:0] r1_ax, r1_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= DW'(i_a_x2) - DW'(i_a_x1);
            r1_dy <= DW'(i_a_y2) - DW'(i_a_y1);
            r1_ex <= DW'(i_b_x2) - DW'(i_b_x1);
            r1_ey <= DW'(i_b_y2) - DW'(i_b_y1);
            r1_wx <= DW'(i_a_x1) - DW'(i_b_x1);
            r1_wy <= DW'(i_a_y1) - DW'(i_b_y1);
            r1_ax <= i_a_x1;
            r1_ay <= i_a_y1;
        end
    end

    // stage 2: six cross-product terms
    logic                         r2_vld;
    logic signed [PW-1:0]         r2_eydx, r2_exdy, r2_exwy, r2_eywx, r2_dxwy, r2_dywx;
    logic signed [DW-1:0]         r2_dx, r2_dy;
    logic signed [COORD_BITS-1:0] r2_ax, r2_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_eydx <= PW'(r1_ey) * PW'(r1_dx);
            r2_exdy <= PW'(r1_ex) * PW'(r1_dy);
            r2_exwy <= PW'(r1_ex) * PW'(r1_wy);
            r2_eywx <= PW'(r1_ey) * PW'(r1_wx);
            r2_dxwy <= PW'(r1_dx) * PW'(r1_wy);
            r2_dywx <= PW'(r1_dy) * PW'(r1_wx);
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
        end
    end

    // stage 3: denominator and numerators, sign made positive
    logic                         r3_vld;
    logic signed [NW-1:0]         r3_den, r3_n1, r3_n2;
    logic signed [DW-1:0]         r3_dx, r3_dy;
    logic signed [COORD_BITS-1:0] r3_ax, r3_ay;
    logic signed [NW-1:0]         n_den, n_n1, n_n2;

    always_comb begin
        n_den = NW'(r2_eydx) - NW'(r2_exdy);
        n_n1  = NW'(r2_exwy) - NW'(r2_eywx);
        n_n2  = NW'(r2_dxwy) - NW'(r2_dywx);
        if (n_den < 0) begin
            n_den = -n_den;
            n_n1  = -n_n1;
            n_n2  = -n_n2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_den <= n_den;
            r3_n1  <= n_n1;
            r3_n2  <= n_n2;
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
        end
    end

    // stage 4: range test, delta magnitudes
    logic                  r4_vld;
    t_side                 r4_side;
    logic [NW-1:0]         r4_n1u;
    logic [COORD_BITS-1:0] r4_magx, r4_magy;
    t_outcome              n_outcome;
    logic signed [DW-1:0]  n_absx, n_absy;

    always_comb begin
        if (r3_den == '0) begin
            n_outcome = OC_PAR;
        end else if (r3_n1 < 0 || r3_n1 > r3_den || r3_n2 < 0 || r3_n2 > r3_den) begin
            n_outcome = OC_MISS;
        end else begin
            n_outcome = OC_HIT;
        end
        n_absx = (r3_dx < 0) ? -r3_dx : r3_dx;
        n_absy = (r3_dy < 0) ? -r3_dy : r3_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side.outcome <= n_outcome;
            r4_side.base_x  <= r3_ax;
            r4_side.base_y  <= r3_ay;
            r4_side.neg_x   <= r3_dx[DW-1];
            r4_side.neg_y   <= r3_dy[DW-1];
            r4_side.den     <= r3_den;
            // misses and parallel items feed a zero numerator into the divider
            r4_n1u          <= (n_outcome == OC_HIT) ? r3_n1 : '0;
            r4_magx         <= n_absx[COORD_BITS-1:0];
            r4_magy         <= n_absy[COORD_BITS-1:0];
        end
    end

    // stage 5: dividend = n1*|delta|*2^F, split into remainder and shift word
    logic [MW-1:0] n_prodx, n_prody;

    assign n_prodx = MW'(r4_n1u) * MW'(r4_magx);
    assign n_prody = MW'(r4_n1u) * MW'(r4_magy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side       <= r4_side;
            o_lane_x.rem <= n_prodx[MW-1:COORD_BITS];
            o_lane_x.low <= QW'(n_prodx[COORD_BITS-1:0]) << FRAC_BITS;
            o_lane_y.rem <= n_prody[MW-1:COORD_BITS];
            o_lane_y.low <= QW'(n_prody[COORD_BITS-1:0]) << FRAC_BITS;
        end
    end

    // a zero denominator always ends as the parallel code
    a_par_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r3_vld && r3_den == '0) |=> (r4_side.outcome == OC_PAR))
        else $error("zero denominator not flagged parallel");

endmodule

/* hdl/segi_div.sv */
// ----------------------------------------------------------------------------
// segi_div: pipelined restoring divider, two lanes sharing one denominator
// One quotient bit per stage over QW stages; side data rides along.
// ----------------------------------------------------------------------------
module segi_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  segi_pkg::t_side i_side,
    input  segi_pkg::t_lane i_lane_x,
    input  segi_pkg::t_lane i_lane_y,
    output logic            o_valid,
    output segi_pkg::t_side o_side,
    output segi_pkg::t_lane o_lane_x,
    output segi_pkg::t_lane o_lane_y
);
    import segi_pkg::*;

    // one compare-subtract step, quotient bit shifts into the low word
    function automatic t_lane div_step(t_lane l, logic [NW-1:0] den);
        logic [NW:0] t;
        logic [NW:0] d;
        logic        qb;
        t_lane       o;
        t  = {l.rem, l.low[QW-1]};
        d  = {1'b0, den};
        qb = (t >= d);
        o.rem = qb ? NW'(t - d) : t[NW-1:0];
        o.low = {l.low[QW-2:0], qb};
        return o;
    endfunction

    logic  r_vld  [QW];
    t_side r_side [QW];
    t_lane r_lx   [QW];
    t_lane r_ly   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic  p_vld;
        t_side p_side;
        t_lane p_lx, p_ly;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_side = i_side;
            assign p_lx   = i_lane_x;
            assign p_ly   = i_lane_y;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_side = r_side[k-1];
            assign p_lx   = r_lx[k-1];
            assign p_ly   = r_ly[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= p_side;
                r_lx[k]   <= div_step(p_lx, p_side.den);
                r_ly[k]   <= div_step(p_ly, p_side.den);
            end
        end
    end

    assign o_valid  = r_vld[QW-1];
    assign o_side   = r_side[QW-1];
    assign o_lane_x = r_lx[QW-1];
    assign o_lane_y = r_ly[QW-1];

    // a hit leaves the divider with a remainder below the denominator
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side.outcome == OC_HIT) |-> (o_lane_x.rem < o_side.den))
        else $error("x remainder not below denominator");

    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side.outcome == OC_HIT) |-> (o_lane_y.rem < o_side.den))
        else $error("y remainder not below denominator");

endmodule

/* hdl/segment_intersection.sv */
// ----------------------------------------------------------------------------
// segment_intersection: 2D segment intersection test with exact hit point
// Takes two segments per item, reports hit/miss/parallel and the crossing
// point in fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries the eight endpoint coordinates.
//   Output channel o_valid/i_ready carries o_outcome, o_cross_x, o_cross_y.
//   o_outcome: 0 hit, 1 no hit, 2 parallel or degenerate; the point fields
//   are zero unless the outcome is a hit.
//   The pipeline has 5 front-end stages (differences, products, sums, range
//   test, dividend products), 24 divider stages (one quotient bit per stage)
//   and one output register. One item is accepted per cycle unless stalled.
//   Reset (i_rst_n low at a clock edge) drops every item in flight; no
//   result appears until new items are accepted.
//   When the receiver holds i_ready low with a result waiting, the whole
//   pipeline freezes and o_ready falls, even with bubbles inside; items enter
//   only if o_valid is low or i_ready high. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module segment_intersection (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_x1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_y1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_x2,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_a_y2,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_x1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_y1,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_x2,
    input  logic signed [segi_pkg::COORD_BITS-1:0]  i_b_y2,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [1:0]                              o_outcome,
    output logic signed [segi_pkg::OUT_W-1:0]       o_cross_x,
    output logic signed [segi_pkg::OUT_W-1:0]       o_cross_y
);
    import segi_pkg::*;

    localparam logic signed [EW-1:0] MAXV = EW'((longint'(1) <<< (OUT_W - 1)) - 1);
    localparam logic signed [EW-1:0] MINV = -EW'(longint'(1) <<< (OUT_W - 1));

    // base*2^F +/- quotient, truncated toward zero, saturated
    function automatic logic signed [OUT_W-1:0] locate(
        logic signed [COORD_BITS-1:0] base,
        logic                         neg,
        t_lane                        l
    );
        logic signed [EW-1:0] a;
        logic signed [EW-1:0] v;
        logic                 rnz;
        a   = EW'(base) <<< FRAC_BITS;
        rnz = (l.rem != '0);
        if (neg) begin
            v = a - $signed(EW'(l.low));
            if (rnz && v > 0) begin
                v = v - EW'(1);
            end
        end else begin
            v = a + $signed(EW'(l.low));
            if (rnz && v < 0) begin
                v = v + EW'(1);
            end
        end
        if (v > MAXV) begin
            v = MAXV;
        end else if (v < MINV) begin
            v = MINV;
        end
        return v[OUT_W-1:0];
    endfunction

    logic  en;
    logic  f_vld, d_vld;
    t_side f_side, d_side;
    t_lane f_lx, f_ly, d_lx, d_ly;

    // whole pipeline advances unless a result waits on a stalled receiver
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    segi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_a_x1   (i_a_x1),
        .i_a_y1   (i_a_y1),
        .i_a_x2   (i_a_x2),
        .i_a_y2   (i_a_y2),
        .i_b_x1   (i_b_x1),
        .i_b_y1   (i_b_y1),
        .i_b_x2   (i_b_x2),
        .i_b_y2   (i_b_y2),
        .o_valid  (f_vld),
        .o_side   (f_side),
        .o_lane_x (f_lx),
        .o_lane_y (f_ly)
    );

    segi_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (f_vld),
        .i_side   (f_side),
        .i_lane_x (f_lx),
        .i_lane_y (f_ly),
        .o_valid  (d_vld),
        .o_side   (d_side),
        .o_lane_x (d_lx),
        .o_lane_y (d_ly)
    );

    // output register
    logic                     r_out_vld;
    t_outcome                 r_outcome;
    logic signed [OUT_W-1:0]  r_cross_x, r_cross_y;
    logic signed [OUT_W-1:0]  n_cross_x, n_cross_y;

    always_comb begin
        if (d_side.outcome == OC_HIT) begin
            n_cross_x = locate(d_side.base_x, d_side.neg_x, d_lx);
            n_cross_y = locate(d_side.base_y, d_side.neg_y, d_ly);
        end else begin
            n_cross_x = '0;
            n_cross_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_outcome <= d_side.outcome;
            r_cross_x <= n_cross_x;
            r_cross_y <= n_cross_y;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_outcome = r_outcome;
    assign o_cross_x = r_cross_x;
    assign o_cross_y = r_cross_y;

    // non-hits carry a zero point
    a_zero_pt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome != OC_HIT) |-> (o_cross_x == '0 && o_cross_y == '0))
        else $error("point nonzero on a non-hit");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
